// File: sv/wrist_motion_awake_detector_assert.svh
// assertion macros for the wrist motion awake detector
`ifndef WRIST_MOTION_AWAKE_DETECTOR_ASSERT_SVH
`define WRIST_MOTION_AWAKE_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WMAD_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication
`define WMAD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define WMAD_ASSERT_IMP(name, clk, rst, ante, cons)
`define WMAD_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: sv/wmad_pkg.sv
// shared types and constants for the wrist motion awake detector
package wmad_pkg;

  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = 8;
  localparam int ACT_W      = 10;
  localparam int COUNT_W    = 16;
  localparam int RUN_W      = 4;
  localparam int WAIT_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LAST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURE_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAYBE_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_THR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_WIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT   = 3'd6;

  // register reset values
  localparam logic [COUNT_W-1:0] RST_WINDOW_LAST = 16'd1500;
  localparam logic [ACT_W-1:0]   RST_SURE_THR    = 10'd15;
  localparam logic [ACT_W-1:0]   RST_MAYBE_THR   = 10'd5;
  localparam logic [ACT_W-1:0]   RST_NO_THR      = 10'd1;
  localparam logic [RUN_W-1:0]   RST_RUN_LIMIT   = 4'd2;
  localparam logic [WAIT_W-1:0]  RST_WAIT_WIN    = 8'd10;
  localparam logic [AXIS_W-1:0]  RST_VAR_LIMIT   = 8'd5;

  localparam logic [AXIS_W-1:0] AXIS_MAX_RESET = 8'd0;
  localparam logic [AXIS_W-1:0] AXIS_MIN_RESET = 8'd255;

  typedef struct packed {
    logic [ACT_W-1:0]  sure_thr;
    logic [ACT_W-1:0]  maybe_thr;
    logic [ACT_W-1:0]  no_thr;
    logic [RUN_W-1:0]  run_limit;
    logic [WAIT_W-1:0] wait_win;
  } class_cfg_t;

  // per-lane control from the top level
  typedef struct packed {
    logic take;     // sample word accepted
    logic close;    // accepted word closes the window
    logic s2_load;  // stage 1 moves into stage 2
    logic s1_worn;  // worn flag of the window in stage 1
  } lane_ctl_t;

endpackage

// File: sv/wmad_lane.sv
// one axis lane: window extremes, range and range change
module wmad_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [wmad_pkg::AXIS_W-1:0]   sample,
  input  wmad_pkg::lane_ctl_t           ctl,
  input  logic [wmad_pkg::AXIS_W-1:0]   var_limit,
  output logic [wmad_pkg::AXIS_W-1:0]   diff
);

  logic [wmad_pkg::AXIS_W-1:0] cur_max;
  logic [wmad_pkg::AXIS_W-1:0] cur_min;
  logic [wmad_pkg::AXIS_W-1:0] cur_max_next;
  logic [wmad_pkg::AXIS_W-1:0] cur_min_next;
  logic [wmad_pkg::AXIS_W-1:0] win_max;
  logic [wmad_pkg::AXIS_W-1:0] win_min;
  logic [wmad_pkg::AXIS_W-1:0] prev_range;
  logic [wmad_pkg::AXIS_W-1:0] rng;
  logic [wmad_pkg::AXIS_W-1:0] prev_eff;

  assign cur_max_next = (sample > cur_max) ? sample : cur_max;
  assign cur_min_next = (sample < cur_min) ? sample : cur_min;

  // running extremes, restarted when a window closes
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_max <= wmad_pkg::AXIS_MAX_RESET;
      cur_min <= wmad_pkg::AXIS_MIN_RESET;
    end else if (ctl.take) begin
      if (ctl.close) begin
        cur_max <= wmad_pkg::AXIS_MAX_RESET;
        cur_min <= wmad_pkg::AXIS_MIN_RESET;
      end else begin
        cur_max <= cur_max_next;
        cur_min <= cur_min_next;
      end
    end
  end

  // stage 1: final extremes of the closed window
  always_ff @(posedge clk) begin
    if (ctl.take && ctl.close) begin
      win_max <= cur_max_next;
      win_min <= cur_min_next;
    end
  end

  assign rng      = (win_max > win_min) ? (win_max - win_min) : '0;
  assign prev_eff = (rng > var_limit) ? '0 : prev_range;

  // stage 2: absolute range change, previous range kept for next window
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_range <= '0;
    end else if (ctl.s2_load) begin
      prev_range <= ctl.s1_worn ? rng : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      diff <= (rng > prev_eff) ? (rng - prev_eff) : (prev_eff - rng);
    end
  end

endmodule

// File: sv/wmad_classify.sv
// merge of lane results: activity sum, hysteresis and awake decision
module wmad_classify (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            load,
  input  logic                                            worn,
  input  logic [wmad_pkg::NUM_AXES-1:0][wmad_pkg::AXIS_W-1:0] diffs,
  input  wmad_pkg::class_cfg_t                            cfg,
  output logic                                            awake,
  output logic [wmad_pkg::ACT_W-1:0]                      activity
);

  logic [wmad_pkg::ACT_W-1:0]  act_sum;
  logic [wmad_pkg::RUN_W-1:0]  run;
  logic [wmad_pkg::RUN_W-1:0]  run_next;
  logic [wmad_pkg::WAIT_W-1:0] wait_cnt;
  logic [wmad_pkg::WAIT_W-1:0] wait_cnt_next;
  logic                        awake_flag;
  logic                        awake_flag_next;

  assign act_sum = wmad_pkg::ACT_W'(diffs[0]) + wmad_pkg::ACT_W'(diffs[1])
                 + wmad_pkg::ACT_W'(diffs[2]);

  always_comb begin
    run_next        = run;
    wait_cnt_next   = wait_cnt;
    awake_flag_next = awake_flag;
    if (!worn) begin
      run_next        = '0;
      wait_cnt_next   = '0;
      awake_flag_next = 1'b1;
    end else if (act_sum > cfg.sure_thr) begin
      run_next        = '0;
      wait_cnt_next   = '0;
      awake_flag_next = 1'b1;
    end else if (act_sum > cfg.maybe_thr) begin
      // moderate activity holds the state
    end else if (act_sum > cfg.no_thr) begin
      if (run < cfg.run_limit) begin
        run_next        = run + 1'b1;
        awake_flag_next = 1'b0;
        wait_cnt_next   = '0;
      end else begin
        awake_flag_next = 1'b1;
        wait_cnt_next   = cfg.wait_win;
      end
    end else begin
      if (run < cfg.run_limit) begin
        run_next        = '0;
        awake_flag_next = 1'b0;
      end else if (wait_cnt != '0) begin
        wait_cnt_next = wait_cnt - 1'b1;
        if (wait_cnt == wmad_pkg::WAIT_W'(1)) begin
          run_next        = '0;
          awake_flag_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= '0;
      wait_cnt   <= '0;
      awake_flag <= 1'b1;
    end else if (load) begin
      run        <= run_next;
      wait_cnt   <= wait_cnt_next;
      awake_flag <= awake_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      awake    <= awake_flag_next;
      activity <= worn ? act_sum : '0;
    end
  end

endmodule

// File: sv/wrist_motion_awake_detector.sv
// top level of the wrist motion awake detector
// usage:
//   slave stream s_* carries one three-axis accelerometer sample per word;
//   s_tuser carries the worn flag, which counts only on the window-closing word.
//   master stream m_* carries one result word per closed window: the awake
//   decision and the activity value (0 when the wrist is not worn).
//   configuration is written through cfg_we/cfg_index/cfg_data while idle.
// throughput: one sample word per clock unless a closing word stalls; three
//   axis lanes run side by side. a window-closing word passes three register
//   stages (lane extremes, lane range change, merge/output register) before
//   m_tvalid rises, the first loaded at the accepting edge.
// stall: words that do not close a window are always taken; a closing word
//   waits only when the two lane stages and the output register are all full,
//   so up to three results may queue behind a stalled receiver.
// reset: rst is synchronous; registers return to their defaults, extremes to
//   0/255, previous ranges and run/wait counters to zero, awake to one.
module wrist_motion_awake_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // accel_x [7:0], accel_y [15:8], accel_z [23:16]
  input  logic        s_tuser,   // worn
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // awake [0], activity [10:1], zero [15:11]
  input  logic        cfg_we,
  input  logic [wmad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmad_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [wmad_pkg::COUNT_W-1:0] window_last;
  logic [wmad_pkg::AXIS_W-1:0]  var_limit;
  wmad_pkg::class_cfg_t         class_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_last         <= wmad_pkg::RST_WINDOW_LAST;
      class_cfg.sure_thr  <= wmad_pkg::RST_SURE_THR;
      class_cfg.maybe_thr <= wmad_pkg::RST_MAYBE_THR;
      class_cfg.no_thr    <= wmad_pkg::RST_NO_THR;
      class_cfg.run_limit <= wmad_pkg::RST_RUN_LIMIT;
      class_cfg.wait_win  <= wmad_pkg::RST_WAIT_WIN;
      var_limit           <= wmad_pkg::RST_VAR_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wmad_pkg::REG_WINDOW_LAST: window_last <= cfg_data;
        wmad_pkg::REG_SURE_THR:    class_cfg.sure_thr  <= cfg_data[wmad_pkg::ACT_W-1:0];
        wmad_pkg::REG_MAYBE_THR:   class_cfg.maybe_thr <= cfg_data[wmad_pkg::ACT_W-1:0];
        wmad_pkg::REG_NO_THR:      class_cfg.no_thr    <= cfg_data[wmad_pkg::ACT_W-1:0];
        wmad_pkg::REG_RUN_LIMIT:   class_cfg.run_limit <= cfg_data[wmad_pkg::RUN_W-1:0];
        wmad_pkg::REG_WAIT_WIN:    class_cfg.wait_win  <= cfg_data[wmad_pkg::WAIT_W-1:0];
        wmad_pkg::REG_VAR_LIMIT:   var_limit <= cfg_data[wmad_pkg::AXIS_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // pipeline control: stage 1 (window extremes), stage 2 (range change),
  // output register (merge result)
  logic s1_valid, s1_worn, s2_valid, s2_worn;
  logic out_ready, s2_ready, s1_ready;
  logic close_now, s_take, s2_load, out_load;
  logic [wmad_pkg::COUNT_W-1:0] sample_counter;

  assign out_ready = !m_tvalid || m_tready;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  // window closes once the counter has reached the limit
  assign close_now = (sample_counter >= window_last);
  assign s_tready  = !close_now || s1_ready;
  assign s_take    = s_tvalid && s_tready;
  assign s2_load   = s1_valid && s2_ready;
  assign out_load  = s2_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
    end else if (s_take) begin
      sample_counter <= close_now ? '0 : sample_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_take && close_now) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (out_load) begin
        s2_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // worn flag travels with the closed window
  always_ff @(posedge clk) begin
    if (s_take && close_now) begin
      s1_worn <= s_tuser;
    end
    if (s2_load) begin
      s2_worn <= s1_worn;
    end
  end

  // axis lanes
  wmad_pkg::lane_ctl_t lane_ctl;
  logic [wmad_pkg::NUM_AXES-1:0][wmad_pkg::AXIS_W-1:0] lane_diff;

  assign lane_ctl.take    = s_take;
  assign lane_ctl.close   = close_now;
  assign lane_ctl.s2_load = s2_load;
  assign lane_ctl.s1_worn = s1_worn;

  for (genvar i = 0; i < wmad_pkg::NUM_AXES; i++) begin : g_lane
    wmad_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .sample    (s_tdata[i*wmad_pkg::AXIS_W +: wmad_pkg::AXIS_W]),
      .ctl       (lane_ctl),
      .var_limit (var_limit),
      .diff      (lane_diff[i])
    );
  end

  // merge and decision, registered into the output word
  logic                       res_awake;
  logic [wmad_pkg::ACT_W-1:0] res_activity;

  wmad_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .worn     (s2_worn),
    .diffs    (lane_diff),
    .cfg      (class_cfg),
    .awake    (res_awake),
    .activity (res_activity)
  );

  assign m_tdata = {5'd0, res_activity, res_awake};

  `include "wrist_motion_awake_detector_assert.svh"

  // non-closing sample words are never held off
  `WMAD_ASSERT_IMP(a_ready_only_on_close, clk, rst, !s_tready, close_now)
  // counter steps by one on every accepted word that keeps the window open
  `WMAD_ASSERT_NEXT(a_count_step, clk, rst, s_take && !close_now,
                    sample_counter == $past(sample_counter) + 1'b1)
  // a new result only comes out of a filled stage 2
  `WMAD_ASSERT_IMP(a_result_source, clk, rst, $rose(m_tvalid), $past(s2_valid))

endmodule

// File: test/testbench.sv
// testbench for the wrist motion awake detector: directed table, then randomized windows
`timescale 1ns / 100ps

module testbench;
  import wmad_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // idle time after the last owed result before touching registers
  localparam int SETTLE_CYCLES   = 6;
  localparam int RANDOM_PHASES   = 13;
  localparam int WORDS_PER_PHASE = 100;
  localparam int IDLE_PERCENT    = 31;

  // one expected result: awake decision and activity value, checked field by field
  typedef struct packed {
    logic             awake;
    logic [ACT_W-1:0] activity;
  } verdict_t;

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_e;

  // one line of the directed table
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
    logic [23:0]           sample;   // accel_z, accel_y, accel_x from the top down
    logic                  worn;
    logic                  typed;    // verdict below is written out by hand
    verdict_t              verdict;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata = '0;   // accel_x [7:0], accel_y [15:8], accel_z [23:16]
  logic                  s_tuser = 1'b0; // worn
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;        // awake [0], activity [10:1], zero [15:11]
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // no random idling on either side while this is set
  bit steady = 1'b0;

  // window and classification settings as the block should hold them
  logic [COUNT_W-1:0] win_last  = RST_WINDOW_LAST;
  logic [ACT_W-1:0]   sure_thr  = RST_SURE_THR;
  logic [ACT_W-1:0]   maybe_thr = RST_MAYBE_THR;
  logic [ACT_W-1:0]   calm_thr  = RST_NO_THR;
  logic [RUN_W-1:0]   run_lim   = RST_RUN_LIMIT;
  logic [WAIT_W-1:0]  wait_win  = RST_WAIT_WIN;
  logic [AXIS_W-1:0]  span_lim  = RST_VAR_LIMIT;

  // motion state of the window in progress
  logic [AXIS_W-1:0]  peak[NUM_AXES];
  logic [AXIS_W-1:0]  trough[NUM_AXES];
  logic [AXIS_W-1:0]  last_span[NUM_AXES];
  logic [COUNT_W-1:0] window_fill;
  logic [RUN_W-1:0]   still_run;
  logic [WAIT_W-1:0]  quiet_wait;
  logic               awake_now;

  // verdicts still owed by the block, oldest first
  verdict_t pending[$];
  verdict_t due;

  int faults       = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int asleep_seen  = 0;
  int settings     = 0;

  wrist_motion_awake_detector uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // everything the off-wrist case and reset put back
  function automatic void clear_motion();
    for (int a = 0; a < NUM_AXES; a++) begin
      peak[a]      = AXIS_MAX_RESET;
      trough[a]    = AXIS_MIN_RESET;
      last_span[a] = '0;
    end
    window_fill = '0;
    still_run   = '0;
    quiet_wait  = '0;
    awake_now   = 1'b1;
  endfunction

  // bits above a register's width are dropped, unknown indexes do nothing
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_WINDOW_LAST: win_last  = value;
      REG_SURE_THR:    sure_thr  = value[ACT_W-1:0];
      REG_MAYBE_THR:   maybe_thr = value[ACT_W-1:0];
      REG_NO_THR:      calm_thr  = value[ACT_W-1:0];
      REG_RUN_LIMIT:   run_lim   = value[RUN_W-1:0];
      REG_WAIT_WIN:    wait_win  = value[WAIT_W-1:0];
      REG_VAR_LIMIT:   span_lim  = value[AXIS_W-1:0];
      default: ;
    endcase
  endfunction

  // folds one accepted sample word into the window, returns 1 when it closes one
  function automatic bit fold_sample(input logic [23:0] word, input logic worn,
                                     output verdict_t v);
    logic [AXIS_W-1:0] s;
    int span;
    int act;
    v = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      s = word[a*AXIS_W +: AXIS_W];
      if (s > peak[a]) peak[a] = s;
      if (s < trough[a]) trough[a] = s;
    end
    if (window_fill < win_last) begin
      window_fill = window_fill + 1'b1;
      return 1'b0;
    end
    window_fill = '0;
    act = 0;
    for (int a = 0; a < NUM_AXES; a++) begin
      // an empty range (max not above min) counts as zero
      span = (peak[a] > trough[a]) ? int'(peak[a]) - int'(trough[a]) : 0;
      // a big swing forgets the last range of that axis
      if (span > int'(span_lim)) last_span[a] = '0;
      act += (span > int'(last_span[a])) ? span - int'(last_span[a])
                                         : int'(last_span[a]) - span;
      peak[a]      = AXIS_MAX_RESET;
      trough[a]    = AXIS_MIN_RESET;
      last_span[a] = AXIS_W'(span);
    end
    if (!worn) begin
      // off the wrist: start over, report awake with no activity
      clear_motion();
      act = 0;
    end else if (act > int'(sure_thr)) begin
      still_run  = '0;
      quiet_wait = '0;
      awake_now  = 1'b1;
    end else if (act > int'(maybe_thr)) begin
      // middle band leaves everything alone
    end else if (act > int'(calm_thr)) begin
      if (still_run < run_lim) begin
        still_run  = still_run + 1'b1;
        awake_now  = 1'b0;
        quiet_wait = '0;
      end else begin
        awake_now  = 1'b1;
        quiet_wait = wait_win;
      end
    end else begin
      if (still_run < run_lim) begin
        still_run = '0;
        awake_now = 1'b0;
      end else if (quiet_wait != 0) begin
        quiet_wait = quiet_wait - 1'b1;
        if (quiet_wait == 0) begin
          still_run = '0;
          awake_now = 1'b0;
        end
      end
    end
    v.awake    = awake_now;
    v.activity = ACT_W'(act);
    return 1'b1;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_REG;
    r.index = idx;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t word_row(input logic [7:0] x, input logic [7:0] y,
                                         input logic [7:0] z, input logic worn);
    plan_row_t r;
    r        = '0;
    r.kind   = ROW_WORD;
    r.sample = {z, y, x};
    r.worn   = worn;
    return r;
  endfunction

  // word row whose verdict is obvious enough to write down
  function automatic plan_row_t seen_row(input logic [7:0] x, input logic [7:0] y,
                                         input logic [7:0] z, input logic worn,
                                         input logic awake, input logic [ACT_W-1:0] act);
    plan_row_t r;
    r                  = word_row(x, y, z, worn);
    r.typed            = 1'b1;
    r.verdict.awake    = awake;
    r.verdict.activity = act;
    return r;
  endfunction

  // offer one sample word, with random gaps ahead of it, and fold it in once taken
  task automatic send_word(input logic [23:0] word, input logic worn,
                           output bit closed, output verdict_t v);
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= worn;
    do @(posedge clk); while (!s_tready);
    closed = fold_sample(word, worn, v);
    words_sent++;
  endtask

  // hold the sender until every owed verdict is in and the pipe has emptied
  task automatic drain_results();
    s_tvalid <= 1'b0;
    cfg_we   <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes keep the enable high; drain_results or send_word lowers it
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_register(idx, value);
  endtask

  // receiver side: random back-pressure
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // result checker, field by field against the oldest owed verdict
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tdata[0] == 1'b0) asleep_seen++;
      if (pending.size() == 0) begin
        $error("result word %h arrived with nothing owed", m_tdata);
        faults++;
      end else begin
        due = pending.pop_front();
        if (m_tdata[0] !== due.awake) begin
          $error("awake: expected %0d, got %0d", due.awake, m_tdata[0]);
          faults++;
        end
        if (m_tdata[ACT_W:1] !== due.activity) begin
          $error("activity: expected %0d, got %0d", due.activity, m_tdata[ACT_W:1]);
          faults++;
        end
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    plan_row_t row;
    bit closed;
    verdict_t v;
    bit last_was_reg;
    int win;
    int sure;
    int maybe;
    int calm;
    int still;
    int quiet;
    int lim;
    int swing;
    int tmp;
    int r;
    logic [7:0] base[NUM_AXES];
    logic [23:0] word;
    logic worn;

    clear_motion();

    // directed table: extremes, every activity band, the odd corners
    plan.push_back(reg_row(REG_WINDOW_LAST, 16'd0));          // one word per window
    plan.push_back(seen_row(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 10'd0)); // flat: asleep
    plan.push_back(seen_row(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 10'd0)); // off the wrist
    plan.push_back(reg_row(REG_WINDOW_LAST, 16'd1));          // two words per window
    plan.push_back(word_row(8'h00, 8'h00, 8'h00, 1'b0));      // worn ignored mid-window
    plan.push_back(seen_row(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 10'd765)); // full swing
    plan.push_back(word_row(8'h00, 8'h00, 8'h00, 1'b1));      // small range, big old one
    plan.push_back(word_row(8'h00, 8'h00, 8'h00, 1'b1));
    plan.push_back(reg_row(REG_WAIT_WIN, 16'd1));
    plan.push_back(word_row(8'h05, 8'h00, 8'h00, 1'b1));      // low band, run starts
    plan.push_back(word_row(8'h07, 8'h00, 8'h01, 1'b1));
    plan.push_back(word_row(8'h09, 8'h09, 8'h09, 1'b1));      // low band, run at limit
    plan.push_back(word_row(8'h09, 8'h09, 8'h09, 1'b1));
    plan.push_back(word_row(8'h00, 8'h00, 8'h00, 1'b1));      // low band past run: wait
    plan.push_back(word_row(8'h03, 8'h00, 8'h00, 1'b1));
    plan.push_back(word_row(8'h00, 8'h00, 8'h00, 1'b1));      // quiet: wait runs out
    plan.push_back(word_row(8'h03, 8'h00, 8'h00, 1'b1));
    plan.push_back(word_row(8'h00, 8'h00, 8'h00, 1'b1));      // middle band
    plan.push_back(word_row(8'h0D, 8'h00, 8'h00, 1'b1));
    plan.push_back(reg_row(REG_WINDOW_LAST, 16'hFFFF));       // longest window
    plan.push_back(word_row(8'h80, 8'h01, 8'hFE, 1'b1));
    plan.push_back(word_row(8'h7F, 8'hFE, 8'h01, 1'b1));
    plan.push_back(word_row(8'h55, 8'hAA, 8'h33, 1'b0));
    plan.push_back(reg_row(REG_WINDOW_LAST, 16'd2));          // count already past limit
    plan.push_back(word_row(8'h40, 8'h41, 8'h42, 1'b1));
    plan.push_back(reg_row(REG_SURE_THR, 16'hFFFF));          // upper bits dropped
    plan.push_back(reg_row(REG_SPARE, 16'h0000));             // unknown index
    plan.push_back(word_row(8'h00, 8'h00, 8'h00, 1'b1));
    plan.push_back(word_row(8'hFF, 8'h00, 8'h00, 1'b1));
    plan.push_back(word_row(8'h00, 8'h00, 8'hFF, 1'b1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    last_was_reg = 1'b0;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        if (!last_was_reg) drain_results();
        write_register(row.index, row.value);
        last_was_reg = 1'b1;
      end else begin
        send_word(row.sample, row.worn, closed, v);
        if (row.typed) pending.push_back(row.verdict);
        else if (closed) pending.push_back(v);
        last_was_reg = 1'b0;
      end
    end
    settings++;

    foreach (base[a]) base[a] = 8'($urandom);
    swing = 0;

    // random phases: each one a fresh setting, then windows of jittery motion
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p == 5 || p == 6);   // a long stretch with no idling at all
      drain_results();
      if (p == 0) begin
        // everything at its floor
        win = 0; sure = 0; maybe = 0; calm = 0; still = 0; quiet = 0; lim = 0;
      end else if (p == 1) begin
        // thresholds and limits at their ceiling, short windows
        win = 1; sure = 765; maybe = 765; calm = 765; still = 15; quiet = 255; lim = 255;
      end else begin
        win   = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
        sure  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 765) : $urandom_range(0, 30);
        maybe = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 765) : $urandom_range(0, sure);
        calm  = $urandom_range(0, maybe);
        still = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
        quiet = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
        lim   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      end
      // junk in the unused upper bits must not matter
      write_register(REG_WINDOW_LAST, CFG_DATA_W'(win));
      write_register(REG_SURE_THR,    CFG_DATA_W'(($urandom & 32'hFC00) | sure));
      write_register(REG_MAYBE_THR,   CFG_DATA_W'(($urandom & 32'hFC00) | maybe));
      write_register(REG_NO_THR,      CFG_DATA_W'(($urandom & 32'hFC00) | calm));
      write_register(REG_RUN_LIMIT,   CFG_DATA_W'(($urandom & 32'hFFF0) | still));
      write_register(REG_WAIT_WIN,    CFG_DATA_W'(($urandom & 32'hFF00) | quiet));
      write_register(REG_VAR_LIMIT,   CFG_DATA_W'(($urandom & 32'hFF00) | lim));
      if ($urandom_range(0, 1) == 0) write_register(REG_SPARE, CFG_DATA_W'($urandom));
      settings++;

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // sender waits out every owed verdict mid-phase
        if (p == 3 && k == WORDS_PER_PHASE / 2) drain_results();
        // motion level drifts: still, tremor, moving, or thrashing
        if ($urandom_range(0, 3) == 0) begin
          r = $urandom_range(0, 99);
          if (r < 20) swing = 0;
          else if (r < 60) swing = $urandom_range(1, 4);
          else if (r < 85) swing = $urandom_range(5, 20);
          else swing = 255;
        end
        for (int a = 0; a < NUM_AXES; a++) begin
          if ($urandom_range(0, 15) == 0) base[a] = 8'($urandom);
          tmp = int'(base[a]) + int'($urandom_range(0, swing));
          word[a*AXIS_W +: AXIS_W] = (tmp > 255) ? 8'd255 : 8'(tmp);
        end
        worn = ($urandom_range(0, 19) != 0);
        send_word(word, worn, closed, v);
        if (closed) pending.push_back(v);
      end
    end
    steady = 1'b0;

    drain_results();

    $display("ran %0d sample words over %0d register settings", words_sent, settings);
    $display("checked %0d result words, %0d of them asleep", results_seen, asleep_seen);
    if (faults == 0) begin
      $display("wrist_motion_awake_detector: match");
    end else begin
      $display("wrist_motion_awake_detector: mismatch");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #5000000;
    $display("wrist_motion_awake_detector: mismatch");
    $finish;
  end

endmodule
